FILE: rtl/lfps_pkg.sv
// shared types, constants and helpers of the line follower steering block
package lfps_pkg;

  // field widths
  localparam int unsigned POS_W       = 13;
  localparam int unsigned SMP_W       = 10;
  localparam int unsigned SMP_FIELDS  = 8;
  localparam int unsigned DUTY_W      = 8;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned EXP_W       = 3;
  localparam int unsigned THR_W       = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 24;

  // controller arithmetic widths
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned NUM_W      = 26;
  localparam int unsigned DIV_W      = 25;
  localparam int unsigned ERR_W      = 13;
  localparam int unsigned DERIV_W    = 14;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned PROD_W     = COEF_W + 1 + INTEG_W;
  localparam int unsigned ACC_W      = PROD_W + 2;
  localparam int unsigned SINT_W     = ACC_W - FRAC_BITS;
  localparam int unsigned SPD_W      = 9;
  localparam int unsigned GAIN_TERMS = 3;

  // constants of the steering law
  localparam int POS_MAX       = 7000;
  localparam int POS_CENTRE    = 3500;
  localparam int BASE_SPEED    = 100;
  localparam int SPD_MAX       = 150;
  localparam int SPD_MIN       = -100;
  localparam int SAMPLE_FULL   = 1000;
  localparam int TURN_DUTY     = 100;
  localparam int TURN_MIN_HITS = 3;
  localparam int THR_RESET     = 500;
  localparam int EXP_RESET     = 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_STOP,
    MODE_PID,
    MODE_RIGHT,
    MODE_LEFT
  } steer_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE,
    REG_KP_GAIN,
    REG_KP_EXP,
    REG_KI_GAIN,
    REG_KI_EXP,
    REG_KD_GAIN,
    REG_KD_EXP,
    REG_THRESHOLD
  } cfg_reg_e;

  // one gain term: mantissa and decimal exponent
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [EXP_W-1:0]  expo;
  } gain_cfg_t;

  // ten to the power of the exponent
  function automatic logic [NUM_W-1:0] pow10(input logic [EXP_W-1:0] e);
    logic [NUM_W-1:0] p;
    unique case (e)
      3'd0:    p = NUM_W'(1);
      3'd1:    p = NUM_W'(10);
      3'd2:    p = NUM_W'(100);
      3'd3:    p = NUM_W'(1000);
      3'd4:    p = NUM_W'(10000);
      3'd5:    p = NUM_W'(100000);
      3'd6:    p = NUM_W'(1000000);
      default: p = NUM_W'(10000000);
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/lfps_coef_div.sv
// bit-serial divider that turns gain mantissa and exponent into q.16 coefficients
module lfps_coef_div (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              recalc_i,
  input  lfps_pkg::gain_cfg_t [lfps_pkg::GAIN_TERMS-1:0]    gains_i,
  output logic [lfps_pkg::GAIN_TERMS-1:0][lfps_pkg::COEF_W-1:0] coef_o,
  output logic                                              busy_o
);

  typedef enum logic {C_IDLE, C_RUN} cstate_e;

  localparam int unsigned STEP_W = $clog2(lfps_pkg::NUM_W);
  localparam int unsigned SEL_W  = $clog2(lfps_pkg::GAIN_TERMS);

  cstate_e                             state_q;
  logic                                dirty_q;
  logic [SEL_W-1:0]                    sel_q;
  logic [STEP_W-1:0]                   step_q;
  logic [lfps_pkg::GAIN_TERMS-1:0][lfps_pkg::COEF_W-1:0] coef_q;
  logic [lfps_pkg::NUM_W-1:0]          num_q;
  logic [lfps_pkg::DIV_W-1:0]          rem_q;
  logic [lfps_pkg::DIV_W-1:0]          div_q;

  logic                                start_c;
  logic                                last_step_c;
  logic                                next_term_c;
  logic [SEL_W-1:0]                    load_sel_c;
  lfps_pkg::gain_cfg_t                 load_gain_c;
  logic [lfps_pkg::DIV_W:0]            trial_c;
  logic                                q_bit_c;
  logic [lfps_pkg::DIV_W-1:0]          rem_n_c;
  logic [lfps_pkg::NUM_W-1:0]          num_n_c;

  // sequencing of the three divisions
  assign start_c     = (state_q == C_IDLE) && dirty_q;
  assign last_step_c = (state_q == C_RUN) && (step_q == STEP_W'(lfps_pkg::NUM_W - 1));
  assign next_term_c = last_step_c && (sel_q != SEL_W'(lfps_pkg::GAIN_TERMS - 1));
  assign load_sel_c  = start_c ? '0 : SEL_W'(sel_q + 1'b1);
  assign load_gain_c = gains_i[load_sel_c];

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial_c = {rem_q, num_q[lfps_pkg::NUM_W-1]};
  assign q_bit_c = trial_c >= {1'b0, div_q};
  assign rem_n_c = q_bit_c ? lfps_pkg::DIV_W'(trial_c - {1'b0, div_q})
                           : trial_c[lfps_pkg::DIV_W-1:0];
  assign num_n_c = {num_q[lfps_pkg::NUM_W-2:0], q_bit_c};

  // control and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      dirty_q <= 1'b0;
      sel_q   <= '0;
      step_q  <= '0;
      coef_q  <= '0;
    end else begin
      if (recalc_i) begin
        dirty_q <= 1'b1;
      end else if (start_c) begin
        dirty_q <= 1'b0;
      end
      unique case (state_q)
        C_IDLE: begin
          if (dirty_q) begin
            state_q <= C_RUN;
            sel_q   <= '0;
            step_q  <= '0;
          end
        end
        C_RUN: begin
          step_q <= STEP_W'(step_q + 1'b1);
          if (last_step_c) begin
            coef_q[sel_q] <= lfps_pkg::COEF_W'(num_n_c);
            step_q        <= '0;
            if (next_term_c) begin
              sel_q <= load_sel_c;
            end else begin
              state_q <= C_IDLE;
            end
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // dividend, divisor and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_c || next_term_c) begin
      // round half up: (gain * 2^17 + d) / (2 d)
      num_q <= lfps_pkg::NUM_W'({load_gain_c.gain, {(lfps_pkg::FRAC_BITS + 1){1'b0}}})
               + lfps_pkg::pow10(load_gain_c.expo);
      div_q <= lfps_pkg::DIV_W'({lfps_pkg::pow10(load_gain_c.expo), 1'b0});
      rem_q <= '0;
    end else if (state_q == C_RUN) begin
      num_q <= num_n_c;
      rem_q <= rem_n_c;
    end
  end

  assign coef_o = coef_q;
  assign busy_o = dirty_q || (state_q == C_RUN);

`ifndef NO_ASSERTIONS
  a_recalc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recalc_i |=> busy_o)
    else $error("coefficient request did not mark the unit busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_RUN) |-> (rem_q < div_q))
    else $error("partial remainder reached the divisor");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_RUN) |-> (sel_q < SEL_W'(lfps_pkg::GAIN_TERMS)))
    else $error("gain term select out of range");
`endif

endmodule

FILE: rtl/line_follower_pid_steering_top.sv
// line follower steering controller: sharp-turn detection and pid on one shared multiplier
// pid tick: S_CLASS, S_MUL_P, S_MUL_I, S_MUL_D, S_ACC, S_SPD_A, S_SPD_B, S_OUT; stop or
//   clear turn: S_CLASS, S_OUT; a centred turn adds S_SCAN; requests are taken in S_IDLE
// the multiplier serves the three gain terms in turn; a gain or exponent write holds
//   tready low while the bit-serial divider rebuilds the coefficients
// reset (rst_ni, async low) clears the config registers to defaults and the pid state to zero
module line_follower_pid_steering_top #(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // line_position[12:0], sample_0..sample_7 10 bits each from bit 13, zero pad
  input  logic [lfps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // request out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // motor_a_reverse[0], motor_a_duty[8:1], motor_b_reverse[9], motor_b_duty[17:10], zero pad
  output logic [lfps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // steer_mode[1:0]
  output logic [lfps_pkg::MODE_W-1:0]         m_axis_tuser,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned SUM_W = $clog2(SENSOR_COUNT * SENSOR_COUNT + 1);
  localparam int unsigned HALF  = SENSOR_COUNT / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_SCAN, S_MUL_P, S_MUL_I, S_MUL_D, S_ACC, S_SPD_A, S_SPD_B, S_OUT
  } state_e;

  // configuration
  logic                                              en_q;
  lfps_pkg::gain_cfg_t [lfps_pkg::GAIN_TERMS-1:0]    gains_q;
  logic [lfps_pkg::THR_W-1:0]                        thr_q;
  logic                                              cfg_we;
  logic                                              recalc;
  logic [lfps_pkg::GAIN_TERMS-1:0][lfps_pkg::COEF_W-1:0] coefs;
  logic                                              coef_busy;

  // sequencer and pid state
  state_e                                state_q;
  logic                                  out_valid_q;
  logic signed [lfps_pkg::ERR_W-1:0]     prev_q;
  logic signed [lfps_pkg::INTEG_W-1:0]   integ_q;

  // datapath registers
  logic [lfps_pkg::POS_W-1:0]            pos_q;
  logic [lfps_pkg::SMP_W-1:0]            smp_q [SENSOR_COUNT];
  logic [lfps_pkg::SMP_W-1:0]            smp_in [SENSOR_COUNT];
  logic signed [lfps_pkg::DERIV_W-1:0]   deriv_q;
  logic signed [lfps_pkg::PROD_W-1:0]    prod_q;
  logic signed [lfps_pkg::ACC_W-1:0]     acc_q;
  logic signed [lfps_pkg::SPD_W-1:0]     sa_q;
  logic [IDX_W-1:0]                      idx_q;
  logic [IDX_W-1:0]                      hi_q;
  logic [lfps_pkg::SMP_W-1:0]            min_q;
  logic [IDX_W-1:0]                      minpos_q;
  logic                                  res_a_rev_q;
  logic [lfps_pkg::DUTY_W-1:0]           res_a_duty_q;
  logic                                  res_b_rev_q;
  logic [lfps_pkg::DUTY_W-1:0]           res_b_duty_q;
  lfps_pkg::steer_mode_e                 res_mode_q;
  logic                                  out_a_rev_q;
  logic [lfps_pkg::DUTY_W-1:0]           out_a_duty_q;
  logic                                  out_b_rev_q;
  logic [lfps_pkg::DUTY_W-1:0]           out_b_duty_q;
  lfps_pkg::steer_mode_e                 out_mode_q;

  // combinational helpers
  logic                                  in_fire;
  logic                                  out_load;
  logic [CNT_W-1:0]                      hit_cnt;
  logic [SUM_W-1:0]                      hit_sum;
  logic [SUM_W-1:0]                      mean_lhs;
  logic [SUM_W-1:0]                      mean_rhs;
  logic [CNT_W-1:0]                      half_cnt;
  logic [IDX_W-1:0]                      win_lo;
  logic [IDX_W-1:0]                      win_hi;
  logic                                  turn_c;
  logic [lfps_pkg::SMP_W-1:0]            scan_smp;
  logic [lfps_pkg::SMP_W-1:0]            min_n;
  logic [IDX_W-1:0]                      minpos_n;
  logic                                  scan_right;
  logic [lfps_pkg::POS_W-1:0]            pos_clip;
  logic signed [lfps_pkg::ERR_W:0]       err_w;
  logic signed [lfps_pkg::ERR_W-1:0]     err_c;
  logic signed [lfps_pkg::DERIV_W-1:0]   deriv_c;
  logic [lfps_pkg::INTEG_W:0]            isum;
  logic signed [lfps_pkg::INTEG_W-1:0]   integ_c;
  logic [lfps_pkg::COEF_W-1:0]           mul_coef;
  logic signed [lfps_pkg::COEF_W:0]      mul_a;
  logic signed [lfps_pkg::INTEG_W-1:0]   mul_b;
  logic signed [lfps_pkg::PROD_W-1:0]    prod_c;
  logic signed [lfps_pkg::ACC_W-1:0]     prod_ext;
  logic signed [lfps_pkg::ACC_W-1:0]     spd_opd;
  logic signed [lfps_pkg::ACC_W-1:0]     spd_q16;
  logic signed [lfps_pkg::SINT_W-1:0]    spd_fl;
  logic signed [lfps_pkg::SINT_W-1:0]    spd_tr;
  logic signed [lfps_pkg::SPD_W-1:0]     spd_c;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == S_IDLE) && !coef_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      thr_q   <= lfps_pkg::THR_W'(lfps_pkg::THR_RESET);
      for (int t = 0; t < lfps_pkg::GAIN_TERMS; t++) begin
        gains_q[t].gain <= '0;
        gains_q[t].expo <= lfps_pkg::EXP_W'(lfps_pkg::EXP_RESET);
      end
    end else if (cfg_we) begin
      unique case (lfps_pkg::cfg_reg_e'(cfg_index_i))
        lfps_pkg::REG_ENABLE:    en_q            <= cfg_data_i[0];
        lfps_pkg::REG_KP_GAIN:   gains_q[0].gain <= cfg_data_i[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_KP_EXP:    gains_q[0].expo <= cfg_data_i[lfps_pkg::EXP_W-1:0];
        lfps_pkg::REG_KI_GAIN:   gains_q[1].gain <= cfg_data_i[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_KI_EXP:    gains_q[1].expo <= cfg_data_i[lfps_pkg::EXP_W-1:0];
        lfps_pkg::REG_KD_GAIN:   gains_q[2].gain <= cfg_data_i[lfps_pkg::GAIN_W-1:0];
        lfps_pkg::REG_KD_EXP:    gains_q[2].expo <= cfg_data_i[lfps_pkg::EXP_W-1:0];
        lfps_pkg::REG_THRESHOLD: thr_q           <= cfg_data_i[lfps_pkg::THR_W-1:0];
      endcase
    end
  end

  // a gain or exponent write needs fresh coefficients
  assign recalc = cfg_we
                  && (lfps_pkg::cfg_reg_e'(cfg_index_i) != lfps_pkg::REG_ENABLE)
                  && (lfps_pkg::cfg_reg_e'(cfg_index_i) != lfps_pkg::REG_THRESHOLD);

  lfps_coef_div u_coef_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .recalc_i (recalc),
    .gains_i  (gains_q),
    .coef_o   (coefs),
    .busy_o   (coef_busy)
  );

  // unpack samples, sensors past the input fields read as zero
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_smp
    if (g < lfps_pkg::SMP_FIELDS) begin : g_live
      assign smp_in[g] = s_axis_tdata[lfps_pkg::POS_W + lfps_pkg::SMP_W * g +: lfps_pkg::SMP_W];
    end else begin : g_zero
      assign smp_in[g] = '0;
    end
  end

  // line hit count, index sum and the centre window
  always_comb begin
    hit_cnt = '0;
    hit_sum = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (smp_q[i] >= thr_q) begin
        hit_cnt = CNT_W'(hit_cnt + 1'b1);
        hit_sum = SUM_W'(hit_sum + SUM_W'(i));
      end
    end
    mean_lhs = SUM_W'({hit_sum, 1'b0});
    mean_rhs = SUM_W'(SUM_W'(SENSOR_COUNT - 1) * SUM_W'(hit_cnt));
    half_cnt = hit_cnt >> 1;
    // half never exceeds the centre, so the window needs no clipping
    win_lo   = IDX_W'(HALF - half_cnt);
    win_hi   = IDX_W'(HALF - 1 + half_cnt);
    turn_c   = hit_cnt >= CNT_W'(lfps_pkg::TURN_MIN_HITS);
  end

  // one window sensor per cycle for the strict minimum
  assign scan_smp   = smp_q[idx_q];
  assign min_n      = (scan_smp < min_q) ? scan_smp : min_q;
  assign minpos_n   = (scan_smp < min_q) ? idx_q : minpos_q;
  assign scan_right = (IDX_W + 1)'({minpos_n, 1'b0}) <= (IDX_W + 1)'(SENSOR_COUNT - 1);

  // error, derivative and saturating integral
  always_comb begin
    pos_clip = (pos_q > lfps_pkg::POS_W'(lfps_pkg::POS_MAX))
               ? lfps_pkg::POS_W'(lfps_pkg::POS_MAX) : pos_q;
    err_w    = (lfps_pkg::ERR_W + 1)'(lfps_pkg::POS_CENTRE) - $signed({1'b0, pos_clip});
    err_c    = err_w[lfps_pkg::ERR_W-1:0];
    deriv_c  = $signed({err_c[lfps_pkg::ERR_W-1], err_c})
               - $signed({prev_q[lfps_pkg::ERR_W-1], prev_q});
    isum     = {integ_q[lfps_pkg::INTEG_W-1], integ_q}
               + {{(lfps_pkg::INTEG_W + 1 - lfps_pkg::ERR_W){err_c[lfps_pkg::ERR_W-1]}}, err_c};
    if (isum[lfps_pkg::INTEG_W] != isum[lfps_pkg::INTEG_W-1]) begin
      integ_c = isum[lfps_pkg::INTEG_W] ? {1'b1, {(lfps_pkg::INTEG_W - 1){1'b0}}}
                                        : {1'b0, {(lfps_pkg::INTEG_W - 1){1'b1}}};
    end else begin
      integ_c = isum[lfps_pkg::INTEG_W-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      S_MUL_I: begin
        mul_coef = coefs[1];
        mul_b    = integ_q;
      end
      S_MUL_D: begin
        mul_coef = coefs[2];
        mul_b    = {{(lfps_pkg::INTEG_W - lfps_pkg::DERIV_W){deriv_q[lfps_pkg::DERIV_W-1]}},
                    deriv_q};
      end
      default: begin
        mul_coef = coefs[0];
        mul_b    = {{(lfps_pkg::INTEG_W - lfps_pkg::ERR_W){prev_q[lfps_pkg::ERR_W-1]}}, prev_q};
      end
    endcase
  end

  assign mul_a    = $signed({1'b0, mul_coef});
  assign prod_c   = mul_a * mul_b;
  assign prod_ext = {{(lfps_pkg::ACC_W - lfps_pkg::PROD_W){prod_q[lfps_pkg::PROD_W-1]}}, prod_q};

  // base speed plus or minus the pid sum, truncated toward zero and clamped
  always_comb begin
    spd_opd = (state_q == S_SPD_B) ? -acc_q : acc_q;
    spd_q16 = lfps_pkg::ACC_W'(lfps_pkg::BASE_SPEED << lfps_pkg::FRAC_BITS) + spd_opd;
    spd_fl  = spd_q16[lfps_pkg::ACC_W-1:lfps_pkg::FRAC_BITS];
    spd_tr  = spd_fl + lfps_pkg::SINT_W'(spd_q16[lfps_pkg::ACC_W-1]
                                       && (spd_q16[lfps_pkg::FRAC_BITS-1:0] != '0));
    if (spd_tr > lfps_pkg::SINT_W'(lfps_pkg::SPD_MAX)) begin
      spd_c = lfps_pkg::SPD_W'(lfps_pkg::SPD_MAX);
    end else if (spd_tr < lfps_pkg::SINT_W'(lfps_pkg::SPD_MIN)) begin
      spd_c = lfps_pkg::SPD_W'(lfps_pkg::SPD_MIN);
    end else begin
      spd_c = spd_tr[lfps_pkg::SPD_W-1:0];
    end
  end

  // sequencer, pid state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      integ_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_CLASS;
        end
        S_CLASS: begin
          if (!en_q) begin
            state_q <= S_OUT;
          end else if (turn_c) begin
            state_q <= (mean_lhs == mean_rhs) ? S_SCAN : S_OUT;
          end else begin
            prev_q  <= err_c;
            integ_q <= integ_c;
            state_q <= S_MUL_P;
          end
        end
        S_SCAN: begin
          if (idx_q == hi_q) state_q <= S_OUT;
        end
        S_MUL_P: state_q <= S_MUL_I;
        S_MUL_I: state_q <= S_MUL_D;
        S_MUL_D: state_q <= S_ACC;
        S_ACC:   state_q <= S_SPD_A;
        S_SPD_A: state_q <= S_SPD_B;
        S_SPD_B: state_q <= S_OUT;
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q <= s_axis_tdata[lfps_pkg::POS_W-1:0];
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        smp_q[i] <= smp_in[i];
      end
    end
    case (state_q)
      S_CLASS: begin
        idx_q    <= win_lo;
        hi_q     <= win_hi;
        min_q    <= lfps_pkg::SMP_W'(lfps_pkg::SAMPLE_FULL);
        minpos_q <= '0;
        deriv_q  <= deriv_c;
        if (!en_q) begin
          res_a_rev_q  <= 1'b0;
          res_a_duty_q <= '0;
          res_b_rev_q  <= 1'b1;
          res_b_duty_q <= '0;
          res_mode_q   <= lfps_pkg::MODE_STOP;
        end else begin
          // turn side from the mean hit index, a tie is settled by the scan
          res_a_rev_q  <= !(mean_lhs < mean_rhs);
          res_b_rev_q  <= !(mean_lhs < mean_rhs);
          res_a_duty_q <= lfps_pkg::DUTY_W'(lfps_pkg::TURN_DUTY);
          res_b_duty_q <= lfps_pkg::DUTY_W'(lfps_pkg::TURN_DUTY);
          res_mode_q   <= (mean_lhs < mean_rhs) ? lfps_pkg::MODE_RIGHT : lfps_pkg::MODE_LEFT;
        end
      end
      S_SCAN: begin
        idx_q    <= IDX_W'(idx_q + 1'b1);
        min_q    <= min_n;
        minpos_q <= minpos_n;
        if (idx_q == hi_q) begin
          res_a_rev_q <= !scan_right;
          res_b_rev_q <= !scan_right;
          res_mode_q  <= scan_right ? lfps_pkg::MODE_RIGHT : lfps_pkg::MODE_LEFT;
        end
      end
      S_MUL_P: prod_q <= prod_c;
      S_MUL_I: begin
        acc_q  <= prod_ext;
        prod_q <= prod_c;
      end
      S_MUL_D: begin
        acc_q  <= acc_q + prod_ext;
        prod_q <= prod_c;
      end
      S_ACC:   acc_q <= acc_q + prod_ext;
      S_SPD_A: sa_q  <= spd_c;
      S_SPD_B: begin
        res_mode_q <= lfps_pkg::MODE_PID;
        if (!sa_q[lfps_pkg::SPD_W-1] && !spd_c[lfps_pkg::SPD_W-1]) begin
          res_a_rev_q  <= 1'b0;
          res_a_duty_q <= lfps_pkg::DUTY_W'(sa_q);
          res_b_rev_q  <= 1'b1;
          res_b_duty_q <= lfps_pkg::DUTY_W'(spd_c);
        end else if (sa_q[lfps_pkg::SPD_W-1]) begin
          res_a_rev_q  <= 1'b0;
          res_a_duty_q <= lfps_pkg::DUTY_W'(-sa_q);
          res_b_rev_q  <= 1'b0;
          res_b_duty_q <= lfps_pkg::DUTY_W'(spd_c);
        end else begin
          res_a_rev_q  <= 1'b1;
          res_a_duty_q <= lfps_pkg::DUTY_W'(sa_q);
          res_b_rev_q  <= 1'b1;
          res_b_duty_q <= lfps_pkg::DUTY_W'(-spd_c);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_a_rev_q  <= res_a_rev_q;
      out_a_duty_q <= res_a_duty_q;
      out_b_rev_q  <= res_b_rev_q;
      out_b_duty_q <= res_b_duty_q;
      out_mode_q   <= res_mode_q;
    end
  end

  // output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = lfps_pkg::OUT_TDATA_W'({out_b_duty_q, out_b_rev_q,
                                                 out_a_duty_q, out_a_rev_q});
  assign m_axis_tuser  = out_mode_q;

`ifndef NO_ASSERTIONS
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_a_duty_q <= lfps_pkg::DUTY_W'(lfps_pkg::SPD_MAX))
                      && (out_b_duty_q <= lfps_pkg::DUTY_W'(lfps_pkg::SPD_MAX)))
    else $error("duty above the speed limit");

  a_turn_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((out_mode_q == lfps_pkg::MODE_RIGHT) || (out_mode_q == lfps_pkg::MODE_LEFT))
    |-> (out_a_duty_q == lfps_pkg::DUTY_W'(lfps_pkg::TURN_DUTY))
        && (out_b_duty_q == lfps_pkg::DUTY_W'(lfps_pkg::TURN_DUTY))
        && (out_a_rev_q == out_b_rev_q))
    else $error("sharp turn with wrong duties or directions");

  a_stop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_mode_q == lfps_pkg::MODE_STOP)
    |-> (out_a_duty_q == '0) && (out_b_duty_q == '0) && out_b_rev_q && !out_a_rev_q)
    else $error("stop command not idle");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_busy |-> !s_axis_tready)
    else $error("request taken while coefficients rebuild");

  a_pid_state_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLASS) && (!en_q || turn_c) |=> $stable(integ_q) && $stable(prev_q))
    else $error("pid state changed outside a pid tick");
`endif

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the line follower steering controller
`timescale 1ns / 100ps

module testbench;
  import lfps_pkg::*;

  localparam int NSENS = int'(SMP_FIELDS);
  localparam int PHASE_ITEMS = 195;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  // one control tick as sent to the block
  typedef struct packed {
    logic [POS_W-1:0]                 pos;
    logic [SMP_FIELDS-1:0][SMP_W-1:0] smp;
  } ctrl_tick_t;

  // one drive command as expected back
  typedef struct {
    logic              a_rev;
    logic [DUTY_W-1:0] a_duty;
    logic              b_rev;
    logic [DUTY_W-1:0] b_duty;
    steer_mode_e       mode;
  } drive_cmd_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [MODE_W-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // register copies and controller state of the predictor
  logic en_sh = 1'b0;
  gain_cfg_t gain_sh [GAIN_TERMS];
  logic [THR_W-1:0] thr_sh = THR_W'(THR_RESET);
  longint prev_err = 0;
  longint err_integ = 0;

  ctrl_tick_t tick_pending [$];
  drive_cmd_t cmd_expect [$];
  logic tick_taken = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatch_cnt = 0;

  line_follower_pid_steering_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_tick(input ctrl_tick_t t);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[POS_W-1:0] = t.pos;
    for (int i = 0; i < NSENS; i++) w[POS_W+SMP_W*i +: SMP_W] = t.smp[i];
    return w;
  endfunction

  // q.16 coefficient, rounded half up
  function automatic longint coef_q16(input gain_cfg_t g);
    longint d;
    d = 1;
    repeat (g.expo) d = d * 10;
    return (longint'(g.gain) * 131072 + d) / (2 * d);
  endfunction

  function automatic longint wheel_speed(input longint q);
    longint s;
    s = q / 65536;
    if (s > SPD_MAX) s = SPD_MAX;
    if (s < SPD_MIN) s = SPD_MIN;
    return s;
  endfunction

  // expected drive command for one tick, advancing the pid state
  function automatic drive_cmd_t steer_predict(input ctrl_tick_t t);
    drive_cmd_t c;
    int hits, idx_sum, half, lo, hi, min_idx;
    logic [SMP_W-1:0] min_val;
    bit right;
    longint pos, err, deriv, acc, sa, sb;
    hits = 0;
    idx_sum = 0;
    for (int i = 0; i < NSENS; i++) begin
      if (t.smp[i] >= thr_sh) begin
        hits++;
        idx_sum += i;
      end
    end
    if (!en_sh) begin
      c.a_rev = 1'b0; c.a_duty = '0; c.b_rev = 1'b1; c.b_duty = '0; c.mode = MODE_STOP;
    end else if (hits >= TURN_MIN_HITS) begin
      if (2 * idx_sum < (NSENS - 1) * hits) begin
        right = 1'b1;
      end else if (2 * idx_sum > (NSENS - 1) * hits) begin
        right = 1'b0;
      end else begin
        // centred mean: lowest sample in the middle window picks the side
        half = hits / 2;
        lo = NSENS / 2 - half;
        hi = NSENS / 2 - 1 + half;
        if (lo < 0) lo = 0;
        if (hi > NSENS - 1) hi = NSENS - 1;
        min_val = SMP_W'(SAMPLE_FULL);
        min_idx = 0;
        for (int i = lo; i <= hi; i++) begin
          if (t.smp[i] < min_val) begin
            min_val = t.smp[i];
            min_idx = i;
          end
        end
        right = (2 * min_idx <= NSENS - 1);
      end
      c.a_rev = !right;
      c.b_rev = !right;
      c.a_duty = DUTY_W'(TURN_DUTY);
      c.b_duty = DUTY_W'(TURN_DUTY);
      c.mode = right ? MODE_RIGHT : MODE_LEFT;
    end else begin
      pos = t.pos;
      if (pos > POS_MAX) pos = POS_MAX;
      err = POS_CENTRE - pos;
      deriv = err - prev_err;
      acc = err_integ + err;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      err_integ = acc;
      prev_err = err;
      acc = coef_q16(gain_sh[0]) * err + coef_q16(gain_sh[1]) * err_integ
          + coef_q16(gain_sh[2]) * deriv;
      sa = wheel_speed(longint'(BASE_SPEED) * 65536 + acc);
      sb = wheel_speed(longint'(BASE_SPEED) * 65536 - acc);
      // sign of each speed picks the motor directions
      if (sa >= 0 && sb >= 0) begin
        c.a_rev = 1'b0; c.a_duty = DUTY_W'(sa); c.b_rev = 1'b1; c.b_duty = DUTY_W'(sb);
      end else if (sa < 0) begin
        c.a_rev = 1'b0; c.a_duty = DUTY_W'(-sa); c.b_rev = 1'b0; c.b_duty = DUTY_W'(sb);
      end else begin
        c.a_rev = 1'b1; c.a_duty = DUTY_W'(sa); c.b_rev = 1'b1; c.b_duty = DUTY_W'(-sb);
      end
      c.mode = MODE_PID;
    end
    return c;
  endfunction

  function automatic ctrl_tick_t tick_from_mask(input int pos, input logic [7:0] mask,
                                                input int hit_val, input int miss_val);
    ctrl_tick_t t;
    t.pos = POS_W'(pos);
    for (int i = 0; i < NSENS; i++) t.smp[i] = SMP_W'(mask[i] ? hit_val : miss_val);
    return t;
  endfunction

  // random tick shaped around the current threshold
  function automatic ctrl_tick_t rand_tick();
    ctrl_tick_t t;
    logic [7:0] mask;
    int kind, sel, cnt, isum, hv, mv;
    bit fixed;
    kind = $urandom_range(99);
    sel = $urandom_range(9);
    if (sel < 7) t.pos = POS_W'($urandom_range(POS_MAX));
    else if (sel == 7) t.pos = POS_W'(POS_CENTRE - 20 + $urandom_range(40));
    else if (sel == 8) t.pos = POS_W'($urandom_range(8191, POS_MAX));
    else t.pos = POS_W'($urandom_range(1) ? POS_MAX : 0);
    if (kind >= 85) begin
      // noise over the whole field range
      t.pos = POS_W'($urandom_range(8191));
      for (int i = 0; i < NSENS; i++) t.smp[i] = SMP_W'($urandom_range(1023));
      return t;
    end
    mask = '0;
    if (kind < 50) begin
      repeat ($urandom_range(2)) mask[$urandom_range(7)] = 1'b1;
    end else if (kind < 70) begin
      do mask = 8'($urandom); while ($countones(mask) < 3);
    end else begin
      // line seen with its mean exactly centred
      do begin
        mask = 8'($urandom);
        cnt = $countones(mask);
        isum = 0;
        for (int i = 0; i < NSENS; i++) if (mask[i]) isum += i;
      end while (cnt < 3 || 2 * isum != (NSENS - 1) * cnt);
    end
    fixed = ($urandom_range(3) == 0);
    hv = $urandom_range(1023, int'(thr_sh));
    mv = (thr_sh == 0) ? hv : $urandom_range(int'(thr_sh) - 1, 0);
    for (int i = 0; i < NSENS; i++) begin
      if (mask[i] || thr_sh == 0) begin
        t.smp[i] = SMP_W'(fixed ? hv : $urandom_range(1023, int'(thr_sh)));
      end else begin
        t.smp[i] = SMP_W'(fixed ? mv : $urandom_range(int'(thr_sh) - 1, 0));
      end
    end
    return t;
  endfunction

  // register write, random junk above the register width
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    case (idx)
      REG_ENABLE:    begin data[0] = val[0];                en_sh = data[0]; end
      REG_KP_GAIN:   begin data[GAIN_W-1:0] = GAIN_W'(val); gain_sh[0].gain = data[GAIN_W-1:0]; end
      REG_KP_EXP:    begin data[EXP_W-1:0] = EXP_W'(val);   gain_sh[0].expo = data[EXP_W-1:0]; end
      REG_KI_GAIN:   begin data[GAIN_W-1:0] = GAIN_W'(val); gain_sh[1].gain = data[GAIN_W-1:0]; end
      REG_KI_EXP:    begin data[EXP_W-1:0] = EXP_W'(val);   gain_sh[1].expo = data[EXP_W-1:0]; end
      REG_KD_GAIN:   begin data[GAIN_W-1:0] = GAIN_W'(val); gain_sh[2].gain = data[GAIN_W-1:0]; end
      REG_KD_EXP:    begin data[EXP_W-1:0] = EXP_W'(val);   gain_sh[2].expo = data[EXP_W-1:0]; end
      REG_THRESHOLD: begin data = THR_W'(val);              thr_sh = data; end
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(input int en, input int kp, input int kpe, input int ki,
                               input int kie, input int kd, input int kde, input int thr);
    write_reg(REG_ENABLE, en);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KP_EXP, kpe);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KI_EXP, kie);
    write_reg(REG_KD_GAIN, kd);
    write_reg(REG_KD_EXP, kde);
    write_reg(REG_THRESHOLD, thr);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_pending.size() != 0 || cmd_expect.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int p);
    case (p % 4)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 70; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 70; end
      default: begin send_idle_pct = 7;  stall_pct = 7;  end
    endcase
    case (p)
      0: apply_setting(1, 0, 0, 0, 0, 0, 0, 500);
      1: apply_setting(1, 255, 0, 255, 0, 255, 0, 1023);
      2: apply_setting(1, $urandom_range(255), 7, $urandom_range(255), 7,
                       $urandom_range(255), 7, 1000);
      3: apply_setting(0, $urandom_range(255), $urandom_range(7), $urandom_range(255),
                       $urandom_range(7), $urandom_range(255), $urandom_range(7),
                       $urandom_range(1023));
      4: apply_setting(1, $urandom_range(255), 2, $urandom_range(255), 2,
                       $urandom_range(255), 2, 0);
      default: apply_setting(1, $urandom_range(255), $urandom_range(4, 1),
                             $urandom_range(255), $urandom_range(4, 1),
                             $urandom_range(255), $urandom_range(4, 1),
                             $urandom_range(900, 200));
    endcase
    repeat (PHASE_ITEMS) tick_pending.push_back(rand_tick());
    // long receiver hold so the block backs up
    if (p == 8) hold_req++;
    wait_drained();
  endtask

  // request acceptance and prediction
  always @(posedge clk_i) begin
    tick_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cmd_expect.push_back(steer_predict(tick_pending[0]));
      void'(tick_pending.pop_front());
    end
  end

  // sender: hold an offered request until taken
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !tick_taken)) begin
      if (tick_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_tick(tick_pending[0]);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result checking against the oldest expectation
  always @(posedge clk_i) begin : result_check
    drive_cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cmd_expect.size() == 0) begin
        note_mismatch($sformatf("unexpected result %0h", m_axis_tdata));
      end else begin
        want = cmd_expect.pop_front();
        check_field("motor_a_reverse", 8'(m_axis_tdata[0]), 8'(want.a_rev));
        check_field("motor_a_duty", m_axis_tdata[8:1], want.a_duty);
        check_field("motor_b_reverse", 8'(m_axis_tdata[9]), 8'(want.b_rev));
        check_field("motor_b_duty", m_axis_tdata[17:10], want.b_duty);
        check_field("steer_mode", 8'(m_axis_tuser), 8'(want.mode));
        check_field("pad bits", 8'(m_axis_tdata[OUT_TDATA_W-1:18]), 8'd0);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    ctrl_tick_t t;
    for (int k = 0; k < GAIN_TERMS; k++) begin
      gain_sh[k].gain = '0;
      gain_sh[k].expo = EXP_W'(EXP_RESET);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // stopped after reset
    tick_pending.push_back(tick_from_mask(1234, 8'hFF, 1000, 0));
    tick_pending.push_back(tick_from_mask(8191, 8'hFF, 1023, 1023));
    wait_drained();

    apply_setting(1, 25, 1, 3, 2, 40, 1, 500);
    // pid extremes and position clamp
    tick_pending.push_back(tick_from_mask(0, 8'h00, 0, 0));
    tick_pending.push_back(tick_from_mask(7000, 8'h00, 0, 499));
    tick_pending.push_back(tick_from_mask(8191, 8'h00, 0, 499));
    tick_pending.push_back(tick_from_mask(3500, 8'h00, 0, 0));
    tick_pending.push_back(tick_from_mask(3501, 8'h00, 0, 0));
    tick_pending.push_back(tick_from_mask(2000, 8'h81, 500, 499));
    // plain sharp turns, hits exactly at threshold
    tick_pending.push_back(tick_from_mask(0, 8'h07, 500, 0));
    tick_pending.push_back(tick_from_mask(0, 8'hE0, 500, 0));
    // centred mean, no sample below full scale, then one sample just below it
    tick_pending.push_back(tick_from_mask(3500, 8'hFF, 1023, 0));
    t = tick_from_mask(3500, 8'hFF, 1000, 0);
    t.smp[7] = 999;
    tick_pending.push_back(t);
    // centred mean, window minimum on each side of the centre
    for (int k = 2; k <= 5; k++) begin
      t = tick_from_mask(100, 8'h3C, 900, 100);
      t.smp[k] = 600;
      tick_pending.push_back(t);
    end
    // equal misses in the window: the first one wins
    tick_pending.push_back(tick_from_mask(5000, 8'h99, 800, 200));
    t = tick_from_mask(5000, 8'h99, 800, 200);
    t.smp[5] = 199;
    tick_pending.push_back(t);
    // centred but not symmetric
    t = tick_from_mask(1, 8'h69, 700, 300);
    t.smp[4] = 250;
    tick_pending.push_back(t);
    tick_pending.push_back(tick_from_mask(3500, 8'h00, 0, 0));
    tick_pending.push_back(tick_from_mask(6999, 8'h00, 0, 0));
    wait_drained();

    for (int p = 0; p < 10; p++) run_phase(p);

    repeat (20) @(posedge clk_i);
    if (cmd_expect.size() != 0) note_mismatch("results still outstanding at the end");
    if (mismatch_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
